/* rtl/random_maze_generator_assert.svh */
// Assertion macros shared by the maze generator RTL
`ifndef RANDOM_MAZE_GENERATOR_ASSERT_SVH
`define RANDOM_MAZE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RMG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("maze generator assertion failed");

// Next-cycle implication
`define RMG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("maze generator assertion failed");

// Implication after a fixed number of cycles
`define RMG_ASSERT_DLY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("maze generator assertion failed");

`endif

/* rtl/rmg_pkg.sv */
// Types, codes and constants of the maze generator
package rmg_pkg;

    localparam int TILE_W    = 8;
    localparam int CFG_W     = 5;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd5;
    localparam logic [31:0]      LFSR_MASK = 32'h8020_0003;
    localparam logic [31:0]      SEED_ZERO_SUB = 32'd1;

    localparam logic FUNC_GEN  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        CELL_FREE = 2'd0,
        CELL_CAND = 2'd1,
        CELL_MAZE = 2'd2
    } cell_state_t;

    typedef enum logic [1:0] {
        DIR_W = 2'd0,
        DIR_N = 2'd1,
        DIR_E = 2'd2,
        DIR_S = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        BRD_TOP    = 2'd0,
        BRD_RIGHT  = 2'd1,
        BRD_BOTTOM = 2'd2,
        BRD_LEFT   = 2'd3
    } border_t;

    typedef struct packed {
        cell_state_t st;
        logic        north;
        logic        west;
    } cell_word_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_MEM,
        S_RD_EVAL,
        S_CLEAR,
        S_WALL,
        S_XDRAW,
        S_XWAIT,
        S_NB_RD,
        S_NB_CHK,
        S_LOOP,
        S_PWAIT,
        S_PREAD,
        S_TAKE,
        S_SH_RD,
        S_SH_WR,
        S_LDRAW,
        S_LRD,
        S_LCHK,
        S_LSELF,
        S_FIN,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic rd_eval;
        logic clr_write;
        logic draw_wall;
        logic start_xdiv;
        logic set_exit;
        logic nb_read;
        logic nb_add;
        logic nb_next;
        logic start_pdiv;
        logic cand_read;
        logic take;
        logic sh_read;
        logic sh_write;
        logic link_draw;
        logic link_read;
        logic link_nb_write;
        logic link_self;
        logic finish;
    } rmg_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic nb_in_grid;
        logic nb_last;
        logic cnt_zero;
        logic sh_done;
        logic link_in_grid;
        logic link_maze;
    } rmg_sts_t;

endpackage

/* rtl/rmg_if.sv */
// Item and result channel interfaces
interface rmg_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] seed;
    logic [5:0]  tile_row;
    logic [5:0]  tile_col;

    modport source (output valid, func, seed, tile_row, tile_col, input ready);
    modport sink   (input valid, func, seed, tile_row, tile_col, output ready);
endinterface

interface rmg_result_if;
    logic       valid;
    logic       ready;
    logic       is_wall;
    logic [5:0] entry_row;
    logic [5:0] entry_col;
    logic [5:0] exit_row;
    logic [5:0] exit_col;

    modport source (output valid, is_wall, entry_row, entry_col, exit_row, exit_col,
                    input ready);
    modport sink   (input valid, is_wall, entry_row, entry_col, exit_row, exit_col,
                    output ready);
endinterface

/* rtl/rmg_mod_unit.sv */
// Bit-serial remainder unit: 32-bit dividend modulo a narrow divisor
module rmg_mod_unit #(
    parameter int DVW = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [31:0]    dividend,
    input  logic [DVW-1:0] divisor,
    output logic           busy,
    output logic [DVW-1:0] rem
);
    import rmg_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          dend_reg, dend_next;
    logic [DVW-1:0]       div_reg, div_next;
    logic [DVW-1:0]       rem_reg, rem_next;
    logic [DVW:0]         trial;

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        cnt_next  = cnt_reg;
        dend_next = dend_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dend_reg[31]};
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_W);
            dend_next = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            dend_next = {dend_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = DVW'(trial - {1'b0, div_reg});
            else
                rem_next = DVW'(trial);
        end
    end

    // Hold the step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Hold operands and partial remainder
    always_ff @(posedge clk)
    begin
        dend_reg <= dend_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

/* rtl/rmg_datapath.sv */
// Maze datapath: cell and candidate stores, random source, openings, tile reads
module rmg_datapath #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [rmg_pkg::CFG_W-1:0] maze_rows,
    input  logic [rmg_pkg::CFG_W-1:0] maze_cols,
    input  logic                     func,
    input  logic [31:0]              seed,
    input  logic [5:0]               tile_row,
    input  logic [5:0]               tile_col,
    input  rmg_pkg::rmg_cmd_t        cmd,
    output rmg_pkg::rmg_sts_t        sts,
    output logic                     is_wall,
    output logic [5:0]               entry_row,
    output logic [5:0]               entry_col,
    output logic [5:0]               exit_row,
    output logic [5:0]               exit_col
);
    import rmg_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CLW   = RW + CW;
    localparam int NCELL = MAX_ROWS * MAX_COLS;
    localparam int CAW   = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int CNTW  = $clog2(NCELL + 1);
    localparam int SZRW  = $clog2(MAX_ROWS + 1);
    localparam int SZCW  = $clog2(MAX_COLS + 1);
    localparam int CELL_DEPTH = 1 << CLW;
    localparam logic [TILE_W-1:0] TR_LIM = TILE_W'(2 * MAX_ROWS + 1);
    localparam logic [TILE_W-1:0] TC_LIM = TILE_W'(2 * MAX_COLS + 1);

    // Neighbour of (r,c) in direction d: {in grid, row, col}
    function automatic logic [CLW:0] nb_of(input dir_t d, input logic [RW-1:0] r,
                                           input logic [CW-1:0] c,
                                           input logic [SZRW-1:0] nrows,
                                           input logic [SZCW-1:0] ncols);
        logic          ok;
        logic [RW-1:0] rr;
        logic [CW-1:0] cc;
        ok = 1'b0;
        rr = r;
        cc = c;
        case (d)
            DIR_W:
            begin
                ok = (c != '0);
                cc = c - 1'b1;
            end
            DIR_N:
            begin
                ok = (r != '0);
                rr = r - 1'b1;
            end
            DIR_E:
            begin
                ok = (TILE_W'(c) + TILE_W'(1) < TILE_W'(ncols));
                cc = c + 1'b1;
            end
            DIR_S:
            begin
                ok = (TILE_W'(r) + TILE_W'(1) < TILE_W'(nrows));
                rr = r + 1'b1;
            end
            default: ok = 1'b0;
        endcase
        return {ok, rr, cc};
    endfunction

    // Tile of the opening carved next to border cell (r,c): {row, col}
    function automatic logic [2*TILE_W-1:0] carve(input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c,
                                                  input logic [SZRW-1:0] nrows,
                                                  input logic [SZCW-1:0] ncols);
        logic [TILE_W-1:0] tr;
        logic [TILE_W-1:0] tc;
        tr = (TILE_W'(r) << 1) | TILE_W'(1);
        tc = (TILE_W'(c) << 1) | TILE_W'(1);
        if (r == '0)
            tr = '0;
        else if (TILE_W'(r) + TILE_W'(1) == TILE_W'(nrows))
            tr = TILE_W'(nrows) << 1;
        else if (c == '0)
            tc = '0;
        else
            tc = TILE_W'(ncols) << 1;
        return {tr, tc};
    endfunction

    // Clamp a configured size into 1..max
    function automatic logic [TILE_W-1:0] clamp(input logic [CFG_W-1:0] v,
                                                input logic [TILE_W-1:0] hi);
        logic [TILE_W-1:0] res;
        res = TILE_W'(v);
        if (v == '0)
            res = TILE_W'(1);
        else if (TILE_W'(v) > hi)
            res = hi;
        return res;
    endfunction

    // Stores
    cell_word_t      cell_mem [CELL_DEPTH];
    logic [CLW-1:0]  cand_mem [NCELL];

    // Registers
    logic [5:0]        tr_reg, tc_reg;
    logic [31:0]       lfsr_reg;
    logic [SZRW-1:0]   cur_rows_reg;
    logic [SZCW-1:0]   cur_cols_reg;
    border_t           wall_reg;
    dir_t              d_reg;
    logic [RW-1:0]     cr_reg, xr_reg, er_reg;
    logic [CW-1:0]     cc_reg, xc_reg, ec_reg;
    logic [1:0]        nb_k_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [CLW-1:0]    clr_reg;
    logic [CAW-1:0]    sh_reg;
    logic [TILE_W-1:0] ent_r_reg, ent_c_reg, ext_r_reg, ext_c_reg;
    logic              gen_done_reg;
    logic              res_wall_reg;
    cell_word_t        cell_rdata_reg;
    logic [CLW-1:0]    cand_rdata_reg;

    // Combinational helpers
    logic [31:0]       lfsr_next;
    logic [CNTW-1:0]   div_rem;
    logic [CNTW-1:0]   div_divisor;
    logic              div_busy;
    dir_t              nb_dir;
    logic [CLW:0]      nb_res;
    logic [CLW:0]      link_res;
    logic [RW-1:0]     x_r;
    logic [CW-1:0]     x_c;
    logic              on_border;
    logic [TILE_W-1:0] trw, tcw, rh, ch;
    logic              rd_wall;
    logic [2*TILE_W-1:0] ent_tile, ext_tile;

    logic              cell_we, cell_re;
    logic [CLW-1:0]    cell_waddr, cell_raddr;
    cell_word_t        cell_wdata;
    logic              cand_we, cand_re;
    logic [CAW-1:0]    cand_waddr, cand_raddr;
    logic [CLW-1:0]    cand_wdata;

    // Advance the Galois LFSR one step
    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);

    // Neighbour order of the growth step: up, down, left, right
    always_comb
    begin
        case (nb_k_reg)
            2'd0:    nb_dir = DIR_N;
            2'd1:    nb_dir = DIR_S;
            2'd2:    nb_dir = DIR_W;
            default: nb_dir = DIR_E;
        endcase
    end

    assign nb_res   = nb_of(nb_dir, cr_reg, cc_reg, cur_rows_reg, cur_cols_reg);
    assign link_res = nb_of(d_reg, cr_reg, cc_reg, cur_rows_reg, cur_cols_reg);

    // Pick the exit cell on the drawn border
    always_comb
    begin
        x_r = '0;
        x_c = '0;
        case (wall_reg)
            BRD_TOP:
            begin
                x_r = '0;
                x_c = CW'(div_rem);
            end
            BRD_RIGHT:
            begin
                x_c = CW'(cur_cols_reg - 1'b1);
                x_r = RW'(div_rem);
            end
            BRD_BOTTOM:
            begin
                x_r = RW'(cur_rows_reg - 1'b1);
                x_c = CW'(div_rem);
            end
            default:
            begin
                x_c = '0;
                x_r = RW'(div_rem);
            end
        endcase
    end

    assign on_border = (cr_reg == '0) || (cc_reg == '0)
                    || (TILE_W'(cr_reg) + TILE_W'(1) == TILE_W'(cur_rows_reg))
                    || (TILE_W'(cc_reg) + TILE_W'(1) == TILE_W'(cur_cols_reg));

    assign ent_tile = carve(er_reg, ec_reg, cur_rows_reg, cur_cols_reg);
    assign ext_tile = carve(xr_reg, xc_reg, cur_rows_reg, cur_cols_reg);

    // Tile read: decode the tile against the cell word read for it
    assign trw = TILE_W'(tr_reg);
    assign tcw = TILE_W'(tc_reg);
    assign rh  = trw >> 1;
    assign ch  = tcw >> 1;

    always_comb
    begin
        rd_wall = 1'b1;
        if (trw < TR_LIM && tcw < TC_LIM && gen_done_reg)
        begin
            if ((trw == ent_r_reg && tcw == ent_c_reg) ||
                (trw == ext_r_reg && tcw == ext_c_reg))
                rd_wall = 1'b0;
            else
            begin
                case ({trw[0], tcw[0]})
                    2'b11: rd_wall = !(rh < TILE_W'(cur_rows_reg) &&
                                       ch < TILE_W'(cur_cols_reg));
                    2'b10: rd_wall = !(rh < TILE_W'(cur_rows_reg) && ch != '0 &&
                                       ch < TILE_W'(cur_cols_reg) && cell_rdata_reg.west);
                    2'b01: rd_wall = !(rh != '0 && rh < TILE_W'(cur_rows_reg) &&
                                       ch < TILE_W'(cur_cols_reg) && cell_rdata_reg.north);
                    default: rd_wall = 1'b1;
                endcase
            end
        end
    end

    // Steer the cell store ports
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        cell_re    = 1'b0;
        cell_raddr = '0;
        if (cmd.clr_write)
        begin
            cell_we    = 1'b1;
            cell_waddr = clr_reg;
        end
        else if (cmd.set_exit)
        begin
            cell_we    = 1'b1;
            cell_waddr = {x_r, x_c};
            cell_wdata = '{st: CELL_MAZE, north: 1'b0, west: 1'b0};
        end
        else if (cmd.nb_add)
        begin
            cell_we    = (cell_rdata_reg.st == CELL_FREE);
            cell_waddr = nb_res[CLW-1:0];
            cell_wdata = '{st: CELL_CAND, north: cell_rdata_reg.north,
                           west: cell_rdata_reg.west};
        end
        else if (cmd.link_nb_write)
        begin
            cell_we    = (d_reg == DIR_E) || (d_reg == DIR_S);
            cell_waddr = link_res[CLW-1:0];
            cell_wdata = '{st: cell_rdata_reg.st,
                           north: cell_rdata_reg.north || (d_reg == DIR_S),
                           west: cell_rdata_reg.west || (d_reg == DIR_E)};
        end
        else if (cmd.link_self)
        begin
            cell_we    = 1'b1;
            cell_waddr = {cr_reg, cc_reg};
            cell_wdata = '{st: CELL_MAZE, north: (d_reg == DIR_N), west: (d_reg == DIR_W)};
        end

        if (cmd.rd_issue)
        begin
            cell_re    = 1'b1;
            cell_raddr = {rh[RW-1:0], ch[CW-1:0]};
        end
        else if (cmd.nb_read)
        begin
            cell_re    = 1'b1;
            cell_raddr = nb_res[CLW-1:0];
        end
        else if (cmd.link_read)
        begin
            cell_re    = 1'b1;
            cell_raddr = link_res[CLW-1:0];
        end
    end

    // Steer the candidate list ports
    always_comb
    begin
        cand_we    = 1'b0;
        cand_waddr = '0;
        cand_wdata = '0;
        cand_re    = 1'b0;
        cand_raddr = '0;
        if (cmd.nb_add)
        begin
            cand_we    = (cell_rdata_reg.st == CELL_FREE);
            cand_waddr = CAW'(cnt_reg);
            cand_wdata = nb_res[CLW-1:0];
        end
        else if (cmd.sh_write)
        begin
            cand_we    = 1'b1;
            cand_waddr = sh_reg;
            cand_wdata = cand_rdata_reg;
        end

        if (cmd.cand_read)
        begin
            cand_re    = 1'b1;
            cand_raddr = CAW'(div_rem);
        end
        else if (cmd.sh_read)
        begin
            cand_re    = 1'b1;
            cand_raddr = CAW'(sh_reg + 1'b1);
        end
    end

    // Cell store
    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        if (cell_re)
            cell_rdata_reg <= cell_mem[cell_raddr];
    end

    // Candidate list store
    always_ff @(posedge clk)
    begin
        if (cand_we)
            cand_mem[cand_waddr] <= cand_wdata;
        if (cand_re)
            cand_rdata_reg <= cand_mem[cand_raddr];
    end

    // Random source, list count, openings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg     <= 32'd1;
            cnt_reg      <= '0;
            ent_r_reg    <= '0;
            ent_c_reg    <= '0;
            ext_r_reg    <= '0;
            ext_c_reg    <= '0;
            gen_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && func == FUNC_GEN)
            begin
                lfsr_reg <= (seed == '0) ? SEED_ZERO_SUB : seed;
                cnt_reg  <= '0;
            end
            else if (cmd.draw_wall || cmd.start_xdiv || cmd.start_pdiv || cmd.link_draw)
                lfsr_reg <= lfsr_next;

            if (cmd.nb_add && cell_rdata_reg.st == CELL_FREE)
                cnt_reg <= cnt_reg + 1'b1;
            else if (cmd.take)
                cnt_reg <= cnt_reg - 1'b1;

            if (cmd.finish)
            begin
                ent_r_reg    <= ent_tile[2*TILE_W-1:TILE_W];
                ent_c_reg    <= ent_tile[TILE_W-1:0];
                ext_r_reg    <= ext_tile[2*TILE_W-1:TILE_W];
                ext_c_reg    <= ext_tile[TILE_W-1:0];
                gen_done_reg <= 1'b1;
            end
        end
    end

    // Working registers of the current item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tr_reg   <= tile_row;
            tc_reg   <= tile_col;
            clr_reg  <= '0;
            if (func == FUNC_GEN)
            begin
                cur_rows_reg <= SZRW'(clamp(maze_rows, TILE_W'(MAX_ROWS)));
                cur_cols_reg <= SZCW'(clamp(maze_cols, TILE_W'(MAX_COLS)));
            end
        end
        if (cmd.clr_write)
            clr_reg <= clr_reg + 1'b1;
        if (cmd.draw_wall)
            wall_reg <= border_t'(lfsr_next[1:0]);
        if (cmd.link_draw)
            d_reg <= dir_t'(lfsr_next[1:0]);
        if (cmd.set_exit)
        begin
            cr_reg   <= x_r;
            cc_reg   <= x_c;
            xr_reg   <= x_r;
            xc_reg   <= x_c;
            er_reg   <= x_r;
            ec_reg   <= x_c;
            nb_k_reg <= '0;
        end
        if (cmd.nb_next)
            nb_k_reg <= nb_k_reg + 1'b1;
        if (cmd.take)
        begin
            cr_reg <= cand_rdata_reg[CLW-1:CW];
            cc_reg <= cand_rdata_reg[CW-1:0];
            sh_reg <= CAW'(div_rem);
        end
        if (cmd.sh_write)
            sh_reg <= sh_reg + 1'b1;
        if (cmd.link_self)
        begin
            nb_k_reg <= '0;
            if (on_border)
            begin
                er_reg <= cr_reg;
                ec_reg <= cc_reg;
            end
        end
        if (cmd.rd_eval)
            res_wall_reg <= rd_wall;
        else if (cmd.finish)
            res_wall_reg <= 1'b0;
    end

    // Shared remainder unit for border and list picks
    assign div_divisor = cmd.start_pdiv ? cnt_reg
                       : ((wall_reg == BRD_TOP || wall_reg == BRD_BOTTOM)
                          ? CNTW'(cur_cols_reg) : CNTW'(cur_rows_reg));

    rmg_mod_unit #(
        .DVW (CNTW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_xdiv || cmd.start_pdiv),
        .dividend (lfsr_next),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // Status back to the controller
    assign sts.clr_last     = (clr_reg == '1);
    assign sts.div_busy     = div_busy;
    assign sts.nb_in_grid   = nb_res[CLW];
    assign sts.nb_last      = (nb_k_reg == 2'd3);
    assign sts.cnt_zero     = (cnt_reg == '0);
    assign sts.sh_done      = (CNTW'(sh_reg) + CNTW'(1) >= cnt_reg + CNTW'(1))
                              && (CNTW'(sh_reg) >= cnt_reg);
    assign sts.link_in_grid = link_res[CLW];
    assign sts.link_maze    = (cell_rdata_reg.st == CELL_MAZE);

    // Result beat payload
    assign is_wall   = res_wall_reg;
    assign entry_row = ent_r_reg[5:0];
    assign entry_col = ent_c_reg[5:0];
    assign exit_row  = ext_r_reg[5:0];
    assign exit_col  = ext_c_reg[5:0];

endmodule

/* rtl/rmg_ctrl.sv */
// Maze controller: sequences reads and the randomized Prim growth
module rmg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_func,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output rmg_pkg::rmg_cmd_t  cmd,
    input  rmg_pkg::rmg_sts_t  sts
);
    import rmg_pkg::*;

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (item_func == FUNC_READ) ? S_RD_MEM : S_CLEAR;
                end
            end
            S_RD_MEM:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_EVAL;
            end
            S_RD_EVAL:
            begin
                cmd.rd_eval = 1'b1;
                state_next  = S_OUT;
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                    state_next = S_WALL;
            end
            S_WALL:
            begin
                cmd.draw_wall = 1'b1;
                state_next    = S_XDRAW;
            end
            S_XDRAW:
            begin
                cmd.start_xdiv = 1'b1;
                state_next     = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.set_exit = 1'b1;
                    state_next   = S_NB_RD;
                end
            end
            S_NB_RD:
            begin
                if (sts.nb_in_grid)
                begin
                    cmd.nb_read = 1'b1;
                    state_next  = S_NB_CHK;
                end
                else if (sts.nb_last)
                    state_next = S_LOOP;
                else
                    cmd.nb_next = 1'b1;
            end
            S_NB_CHK:
            begin
                cmd.nb_add = 1'b1;
                if (sts.nb_last)
                    state_next = S_LOOP;
                else
                begin
                    cmd.nb_next = 1'b1;
                    state_next  = S_NB_RD;
                end
            end
            S_LOOP:
            begin
                if (sts.cnt_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.start_pdiv = 1'b1;
                    state_next     = S_PWAIT;
                end
            end
            S_PWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_PREAD;
            end
            S_PREAD:
            begin
                cmd.cand_read = 1'b1;
                state_next    = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (sts.sh_done)
                    state_next = S_LDRAW;
                else
                begin
                    cmd.sh_read = 1'b1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.sh_write = 1'b1;
                state_next   = S_SH_RD;
            end
            S_LDRAW:
            begin
                cmd.link_draw = 1'b1;
                state_next    = S_LRD;
            end
            S_LRD:
            begin
                if (sts.link_in_grid)
                begin
                    cmd.link_read = 1'b1;
                    state_next    = S_LCHK;
                end
                else
                    state_next = S_LDRAW;
            end
            S_LCHK:
            begin
                if (sts.link_maze)
                begin
                    cmd.link_nb_write = 1'b1;
                    state_next        = S_LSELF;
                end
                else
                    state_next = S_LDRAW;
            end
            S_LSELF:
            begin
                cmd.link_self = 1'b1;
                state_next    = S_NB_RD;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (result_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);

endmodule

/* rtl/random_maze_generator.sv */
// Random maze generator top level: configuration port, channels, controller and datapath
// Builds a maze of maze_rows by maze_cols cells (clamped to 1..MAX_ROWS/MAX_COLS) with
// randomized Prim growth from a 32-bit LFSR seeded by a generate beat, then answers tile
// reads. One item is in work at a time and each item gives one result beat. A read's result
// beat is valid once one cell store read and one decode have been registered. A generate
// first sweeps the cell store, one entry a cycle, over 2**(clog2(MAX_ROWS) + clog2(MAX_COLS))
// entries (256 at the defaults), then for each added cell starts and waits on the
// bit-serial remainder unit that picks a list position, reads and takes the entry, moves
// the later list entries down to close the gap, draws neighbours until one in the maze is
// found to link to, and checks each neighbour for the list; run time is set mostly by the
// remainder unit and the list compaction.
`include "random_maze_generator_assert.svh"

module random_maze_generator #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    rmg_item_if.sink     item,
    rmg_result_if.source result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rmg_pkg::*;

    logic [CFG_W-1:0] maze_rows_reg;
    logic [CFG_W-1:0] maze_cols_reg;
    logic             cfg_write;
    rmg_cmd_t         cmd;
    rmg_sts_t         sts;

    // Register writes land on the access beat
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_rows_reg <= CFG_RESET;
            maze_cols_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_ROWS: maze_rows_reg <= pwdata[CFG_W-1:0];
                REG_COLS: maze_cols_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS: prdata = 32'(maze_rows_reg);
            REG_COLS: prdata = 32'(maze_cols_reg);
            default:  prdata = '0;
        endcase
    end

    rmg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_func    (item.func),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    rmg_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .maze_rows (maze_rows_reg),
        .maze_cols (maze_cols_reg),
        .func      (item.func),
        .seed      (item.seed),
        .tile_row  (item.tile_row),
        .tile_col  (item.tile_col),
        .cmd       (cmd),
        .sts       (sts),
        .is_wall   (result.is_wall),
        .entry_row (result.entry_row),
        .entry_col (result.entry_col),
        .exit_row  (result.exit_row),
        .exit_col  (result.exit_col)
    );

    // A read beat is answered after the cell store read and decode states
    `RMG_ASSERT_DLY(a_read_latency, item.valid && item.ready && item.func == FUNC_READ, 3, result.valid)
    // No new item is taken while a result beat waits
    `RMG_ASSERT_IMP(a_one_in_flight, result.valid, !item.ready)
    // Each item yields exactly one result beat
    `RMG_ASSERT_NXT(a_single_beat, result.valid && result.ready, !result.valid)

endmodule
